/* rtl/sfr_pkg.sv */
// Shared types and constants for the start/length/XOR serial frame receiver.
// No dependencies.
`timescale 1ns / 1ps

package sfr_pkg;

   localparam int unsigned BYTE_W  = 8;
   localparam int unsigned COUNT_W = 32;

   localparam logic [BYTE_W-1:0] START_BYTE_RESET = 8'd254;
   localparam logic [BYTE_W-1:0] MAX_LEN_RESET    = 8'd250;
   localparam logic [BYTE_W-1:0] LEN_LIMIT        = 8'd252;
   localparam logic [BYTE_W-1:0] HEADER_EXTRA     = 8'd3;

   typedef enum logic [0:0] {
      CSR_START_BYTE = 1'b0,
      CSR_MAX_LEN    = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_LEN   = 2'd1,
      PH_BODY  = 2'd2,
      PH_CHECK = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BODY  = 2'd0,
      KIND_GOOD  = 2'd1,
      KIND_BAD   = 2'd2,
      KIND_ABORT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [BYTE_W-1:0]  out_byte;
      logic [BYTE_W-1:0]  out_index;
      kind_type           out_kind;
      logic [COUNT_W-1:0] bad_check_count;
   } rsp_type;

endpackage

/* rtl/sfr_in_reg.sv */
// Input register stage: captures one received byte per transaction.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                      advance,
   output logic                      s1_valid,
   output logic [sfr_pkg::BYTE_W-1:0] s1_byte
);
   import sfr_pkg::*;

   logic              s1_valid_ff, s1_valid_in;
   logic [BYTE_W-1:0] s1_byte_ff, s1_byte_in;
   logic              load;

   always_comb begin
      req_stall   = s1_valid_ff && !advance;
      load        = req_valid && !req_stall;
      s1_valid_in = load ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
      s1_byte_in  = load ? req_rx_byte : s1_byte_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_byte_ff <= s1_byte_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_byte  = s1_byte_ff;

endmodule

/* rtl/sfr_parser.sv */
// Frame state machine: phase, body count, running XOR and check error tally.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      advance,
   input  logic [sfr_pkg::BYTE_W-1:0] rx_byte,
   input  logic [sfr_pkg::BYTE_W-1:0] start_byte,
   input  logic [sfr_pkg::BYTE_W-1:0] max_len,
   output logic                      emit,
   output sfr_pkg::rsp_type          result
);
   import sfr_pkg::*;

   phase_type          phase_ff, phase_in;
   logic [BYTE_W-1:0]  total_ff, total_in;
   logic [BYTE_W-1:0]  index_ff, index_in;
   logic [BYTE_W-1:0]  xor_ff, xor_in;
   logic [COUNT_W-1:0] tally_ff, tally_in;
   logic [BYTE_W-1:0]  xor_next;

   always_comb begin
      phase_in = phase_ff;
      total_in = total_ff;
      index_in = index_ff;
      xor_in   = xor_ff;
      tally_in = tally_ff;
      xor_next = xor_ff ^ rx_byte;
      emit     = 1'b0;
      result.out_byte  = rx_byte;
      result.out_index = '0;
      result.out_kind  = KIND_BODY;
      unique case (phase_ff)
         PH_HUNT: begin
            if (rx_byte == start_byte) begin
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            emit = 1'b1;
            if (rx_byte > max_len || rx_byte > LEN_LIMIT) begin
               phase_in        = PH_HUNT;
               result.out_kind = KIND_ABORT;
            end else begin
               total_in = rx_byte + HEADER_EXTRA;
               index_in = 8'd1;
               xor_in   = rx_byte;
               phase_in = PH_BODY;
            end
         end
         PH_BODY: begin
            emit             = 1'b1;
            xor_in           = xor_next;
            index_in         = index_ff + 8'd1;
            result.out_index = index_ff;
            if (index_in == total_ff) begin
               phase_in = PH_CHECK;
            end
         end
         PH_CHECK: begin
            emit             = 1'b1;
            phase_in         = PH_HUNT;
            result.out_index = total_ff;
            if (xor_next == '0) begin
               result.out_kind = KIND_GOOD;
            end else begin
               result.out_kind = KIND_BAD;
               tally_in        = tally_ff + 32'd1;
            end
         end
         default: phase_in = PH_HUNT;
      endcase
      result.bad_check_count = tally_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
         total_ff <= '0;
         index_ff <= '0;
         xor_ff   <= '0;
         tally_ff <= '0;
      end else if (advance) begin
         phase_ff <= phase_in;
         total_ff <= total_in;
         index_ff <= index_in;
         xor_ff   <= xor_in;
         tally_ff <= tally_in;
      end
   end

endmodule

/* rtl/sfr_out_reg.sv */
// Result register: holds one result transaction until the receiver takes it.
// Depends on sfr_pkg.
`timescale 1ns / 1ps

module sfr_out_reg (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  sfr_pkg::rsp_type result,
   output logic             out_free,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sfr_pkg::rsp_type rsp_data
);
   import sfr_pkg::*;

   logic    valid_ff, valid_in;
   rsp_type data_ff, data_in;

   always_comb begin
      out_free = !valid_ff || !rsp_stall;
      valid_in = load ? 1'b1 : (out_free ? 1'b0 : valid_ff);
      data_in  = load ? result : data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

/* rtl/sof_length_xor_frame_receiver_top.sv */
// Start/length/XOR serial frame receiver, top level.
// Path: an accepted byte is held in the input register, and its result (if any) is held in the result register.
// Throughput: one byte per cycle; the input register advances whenever the
// result register is empty or being taken.
// Reset (synchronous): hunting for the start byte, counters and tally zero,
// start byte 254, max data length 250.
`timescale 1ns / 1ps

module sof_length_xor_frame_receiver_top (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]  req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [sfr_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic [sfr_pkg::BYTE_W-1:0]  rsp_out_index,
   output logic [1:0]                 rsp_out_kind,
   output logic [sfr_pkg::COUNT_W-1:0] rsp_bad_check_count,
   input  logic                       csr_write_en,
   input  logic [0:0]                 csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]  csr_wdata
);
   import sfr_pkg::*;

   logic [BYTE_W-1:0] start_byte_ff, start_byte_in;
   logic [BYTE_W-1:0] max_len_ff, max_len_in;
   logic              s1_valid;
   logic [BYTE_W-1:0] s1_byte;
   logic              advance;
   logic              out_free;
   logic              emit;
   rsp_type           result;
   rsp_type           rsp_data;

   always_comb begin
      start_byte_in = start_byte_ff;
      max_len_in    = max_len_ff;
      if (csr_write_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_BYTE: start_byte_in = csr_wdata;
            CSR_MAX_LEN:    max_len_in    = csr_wdata;
            default:        start_byte_in = start_byte_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= START_BYTE_RESET;
         max_len_ff    <= MAX_LEN_RESET;
      end else begin
         start_byte_ff <= start_byte_in;
         max_len_ff    <= max_len_in;
      end
   end

   assign advance = s1_valid && out_free;

   sfr_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_rx_byte(req_rx_byte),
      .advance    (advance),
      .s1_valid   (s1_valid),
      .s1_byte    (s1_byte)
   );

   sfr_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .rx_byte   (s1_byte),
      .start_byte(start_byte_ff),
      .max_len   (max_len_ff),
      .emit      (emit),
      .result    (result)
   );

   sfr_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && emit),
      .result   (result),
      .out_free (out_free),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   assign rsp_out_byte        = rsp_data.out_byte;
   assign rsp_out_index       = rsp_data.out_index;
   assign rsp_out_kind        = rsp_data.out_kind;
   assign rsp_bad_check_count = rsp_data.bad_check_count;

   a_stall_needs_item: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid)
      else $error("input stalled with empty input register");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |-> !advance)
      else $error("input stage advanced into a held result");

   a_abort_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.out_kind == KIND_ABORT) |-> rsp_data.out_index == '0)
      else $error("abort result with nonzero index");

   a_end_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.out_kind == KIND_GOOD || rsp_data.out_kind == KIND_BAD))
      |-> rsp_data.out_index >= HEADER_EXTRA)
      else $error("frame end index below header size");

endmodule

/* test/sof_length_xor_frame_receiver_checker.sv */
// Checker for the serial frame receiver: follows register writes and accepted bytes,
// predicts each result and compares it with what the block returns. Depends on sfr_pkg.
`timescale 1ns / 1ps

module sof_length_xor_frame_receiver_checker (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   input  logic                        req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]  req_rx_byte,
   input  logic                        rsp_valid,
   input  logic                        rsp_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]  rsp_out_byte,
   input  logic [sfr_pkg::BYTE_W-1:0]  rsp_out_index,
   input  logic [1:0]                  rsp_out_kind,
   input  logic [sfr_pkg::COUNT_W-1:0] rsp_bad_check_count,
   input  logic                        csr_write_en,
   input  logic [0:0]                  csr_index,
   input  logic [sfr_pkg::BYTE_W-1:0]  csr_wdata,
   output int unsigned                 mismatch_count,
   output int unsigned                 results_due
);
   import sfr_pkg::*;

   phase_type          frame_phase;
   logic [BYTE_W-1:0]  start_value;
   logic [BYTE_W-1:0]  max_length;
   logic [BYTE_W-1:0]  body_size;
   logic [BYTE_W-1:0]  body_pos;
   logic [BYTE_W-1:0]  xor_acc;
   logic [COUNT_W-1:0] bad_frames;
   rsp_type            frame_results_due[$];
   int unsigned        fails = 0;

   task automatic predict_frame_byte(input logic [BYTE_W-1:0] rx);
      rsp_type r;
      bit      emit;
      emit       = 1'b1;
      r.out_byte = rx;
      r.out_index = '0;
      r.out_kind = KIND_BODY;
      case (frame_phase)
         PH_HUNT: begin
            emit = 1'b0;
            if (rx == start_value) frame_phase = PH_LEN;
         end
         PH_LEN: begin
            if (rx > max_length || rx > LEN_LIMIT) begin
               frame_phase = PH_HUNT;
               r.out_kind  = KIND_ABORT;
            end else begin
               body_size   = rx + HEADER_EXTRA;
               body_pos    = 8'd1;
               xor_acc     = rx;
               frame_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            r.out_index = body_pos;
            xor_acc     = xor_acc ^ rx;
            body_pos    = body_pos + 8'd1;
            if (body_pos == body_size) frame_phase = PH_CHECK;
         end
         default: begin
            r.out_index = body_size;
            if ((xor_acc ^ rx) == '0) begin
               r.out_kind = KIND_GOOD;
            end else begin
               r.out_kind = KIND_BAD;
               bad_frames = bad_frames + 1'b1;
            end
            frame_phase = PH_HUNT;
         end
      endcase
      r.bad_check_count = bad_frames;
      if (emit) frame_results_due.push_back(r);
   endtask

   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      if (reset) begin
         frame_phase = PH_HUNT;
         start_value = START_BYTE_RESET;
         max_length  = MAX_LEN_RESET;
         body_size   = '0;
         body_pos    = '0;
         xor_acc     = '0;
         bad_frames  = '0;
         frame_results_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            got = {rsp_out_byte, rsp_out_index, kind_type'(rsp_out_kind), rsp_bad_check_count};
            if (frame_results_due.size() == 0) begin
               fails++;
               if (fails <= 10)
                  $display("%0t: unexpected transaction: byte %h index %0d kind %0d count %0d",
                           $realtime, got.out_byte, got.out_index, got.out_kind,
                           got.bad_check_count);
            end else begin
               want = frame_results_due.pop_front();
               if (got !== want) begin
                  fails++;
                  if (fails <= 10)
                     $display({"%0t: mismatch: expected byte %h index %0d kind %0d count %0d,",
                               " got byte %h index %0d kind %0d count %0d"},
                              $realtime, want.out_byte, want.out_index, want.out_kind,
                              want.bad_check_count, got.out_byte, got.out_index,
                              got.out_kind, got.bad_check_count);
               end
            end
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_START_BYTE: start_value = csr_wdata;
               CSR_MAX_LEN:    max_length  = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) predict_frame_byte(req_rx_byte);
      end
      mismatch_count <= fails;
      results_due    <= frame_results_due.size();
   end

endmodule

/* test/sof_length_xor_frame_receiver_top_tb.sv */
// Testbench top for the serial frame receiver: clock, reset, byte and register stimulus,
// verdict. Depends on sfr_pkg, sof_length_xor_frame_receiver_top and the checker module.
`timescale 1ns / 1ps

module sof_length_xor_frame_receiver_top_tb;
   import sfr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 300000;
   localparam int unsigned ITEM_GOAL   = 1200;
   localparam int unsigned WHOLE_FRAME = 1000;

   logic               clock        = 1'b0;
   logic               reset        = 1'b1;
   logic               req_valid    = 1'b0;
   logic [BYTE_W-1:0]  req_rx_byte  = '0;
   logic               rsp_stall    = 1'b0;
   logic               csr_write_en = 1'b0;
   logic [0:0]         csr_index    = '0;
   logic [BYTE_W-1:0]  csr_wdata    = '0;
   logic               req_stall;
   logic               rsp_valid;
   logic [BYTE_W-1:0]  rsp_out_byte;
   logic [BYTE_W-1:0]  rsp_out_index;
   logic [1:0]         rsp_out_kind;
   logic [COUNT_W-1:0] rsp_bad_check_count;

   int unsigned        mismatch_count;
   int unsigned        results_due;
   int unsigned        cycle_count  = 0;
   int unsigned        idle_pct     = 0;
   int unsigned        bytes_sent   = 0;
   logic [BYTE_W-1:0]  start_value  = START_BYTE_RESET;
   logic [BYTE_W-1:0]  max_length   = MAX_LEN_RESET;

   sof_length_xor_frame_receiver_top uut (.*);

   sof_length_xor_frame_receiver_checker checker_i (.*);

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_byte(input logic [BYTE_W-1:0] value);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [BYTE_W-1:0] value);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= value;
      if (idx == CSR_START_BYTE) start_value = value;
      else max_length = value;
      @(posedge clock);
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   // keep limits the bytes sent after the length; short keeps give truncated frames
   task automatic send_frame(input logic [BYTE_W-1:0] len, input bit good_check,
                             input int unsigned keep);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] data;
      int unsigned       n;
      send_byte(start_value);
      send_byte(len);
      bytes_sent += 2;
      if (len > max_length || len > LEN_LIMIT) return;
      acc = len;
      for (n = 0; n < len + 2 && n < keep; n++) begin
         data = 8'($urandom);
         acc  = acc ^ data;
         send_byte(data);
         bytes_sent++;
      end
      if (keep > len + 2) begin
         send_byte(good_check ? acc : acc ^ 8'($urandom_range(1, 255)));
         bytes_sent++;
      end
   endtask

   initial begin
      int unsigned       pick;
      int unsigned       phase_end;
      logic [BYTE_W-1:0] len;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      idle_pct = 20;
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(START_BYTE_RESET);
      send_byte(8'd0);
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'hFF);
      send_byte(START_BYTE_RESET);
      send_byte(8'd1);
      send_byte(8'h12);
      send_byte(8'h34);
      send_byte(8'h80);
      send_byte(8'h00);
      send_byte(START_BYTE_RESET);
      send_byte(MAX_LEN_RESET + 8'd1);
      send_byte(START_BYTE_RESET);
      send_byte(8'hFF);
      drain();
      write_reg(CSR_START_BYTE, 8'h00);
      write_reg(CSR_MAX_LEN, LEN_LIMIT);
      send_byte(8'h00);
      send_byte(LEN_LIMIT + 8'd1);
      // max length lowered between start byte and length
      send_byte(8'h00);
      drain();
      write_reg(CSR_MAX_LEN, 8'd0);
      send_byte(8'd1);
      send_frame(8'd0, 1'b1, WHOLE_FRAME);
      drain();
      write_reg(CSR_START_BYTE, 8'hFF);
      send_frame(8'd0, 1'b0, WHOLE_FRAME);
      bytes_sent = 0;

      while (bytes_sent < ITEM_GOAL) begin
         drain();
         case ($urandom_range(0, 2))
            0:       idle_pct = 0;
            1:       idle_pct = 10;
            default: idle_pct = 30;
         endcase
         if (bytes_sent > ITEM_GOAL * 4 / 5) idle_pct = 0;
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_START_BYTE, 8'h00);
            1:       write_reg(CSR_START_BYTE, 8'hFF);
            2:       write_reg(CSR_START_BYTE, START_BYTE_RESET);
            default: write_reg(CSR_START_BYTE, 8'($urandom));
         endcase
         case ($urandom_range(0, 3))
            0:       write_reg(CSR_MAX_LEN, 8'd0);
            1:       write_reg(CSR_MAX_LEN, LEN_LIMIT);
            2:       write_reg(CSR_MAX_LEN, MAX_LEN_RESET);
            default: write_reg(CSR_MAX_LEN, 8'($urandom_range(0, LEN_LIMIT)));
         endcase
         phase_end = bytes_sent + $urandom_range(60, 140);
         while (bytes_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
               repeat ($urandom_range(1, 4)) begin
                  send_byte(8'($urandom));
                  bytes_sent++;
               end
            end else if (pick < 16) begin
               send_frame(8'($urandom_range(0, 5)), 1'b1, $urandom_range(0, 4));
            end else begin
               if (pick < 17) len = max_length;
               else if (pick < 24) len = 8'($urandom);
               else len = 8'($urandom_range(0, 12));
               send_frame(len, $urandom_range(0, 4) != 0, WHOLE_FRAME);
            end
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
